/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file gmsp_chk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("checker: same-cycle property failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("checker: next-cycle property failed");

`endif

/* rtl/gmsp_pkg.sv */
// ----------------------------------------------------------------------------
// gmsp_pkg
// Types, constants and arithmetic helpers of the geared motor speed panel.
// ----------------------------------------------------------------------------
`default_nettype none

package gmsp_pkg;

    localparam logic [1:0] GEAR_1TO1   = 2'd0;
    localparam logic [1:0] GEAR_1TO5   = 2'd1;
    localparam logic [1:0] GEAR_16TO1  = 2'd2;
    localparam logic [1:0] GEAR_UNUSED = 2'd3;

    localparam int SPEED_W = 18;

    localparam logic [SPEED_W-1:0] SAVED_RST_1TO1  = 18'd2000;
    localparam logic [SPEED_W-1:0] SAVED_RST_1TO5  = 18'd10000;
    localparam logic [SPEED_W-1:0] SAVED_RST_16TO1 = 18'd100;
    localparam logic [4:0]         LED_RST         = 5'h12;
    localparam logic [7:0]         CRC_POLY        = 8'h8C;

    typedef struct packed {
        logic mode_key;
        logic run_key_long;
        logic run_key_release;
        logic up_key;
        logic down_key;
    } t_in_beat;

    typedef struct packed {
        logic [5:0]  thousands_byte;
        logic [7:0]  flags_byte;
        logic        spare_byte;
        logic [7:0]  check_byte;
        logic [15:0] motor_speed;
        logic [4:0]  led_pattern;
        logic [3:0]  digit_low;
        logic [2:0]  digit_high;
        logic [1:0]  gear_now;
        logic        last_frame;
    } t_out_beat;

    typedef struct packed {
        logic [1:0]         gear;
        logic [SPEED_W-1:0] set_speed;
        logic               running;
        logic               reverse;
        logic [4:0]         led;
        logic               last;
    } t_snap;

    function automatic logic [SPEED_W-1:0] step_of(input logic [1:0] g);
        logic [SPEED_W-1:0] s;
        unique case (g)
            GEAR_1TO5:  s = 18'd10000;
            GEAR_16TO1: s = 18'd100;
            default:    s = 18'd1000;
        endcase
        return s;
    endfunction

    function automatic logic [SPEED_W-1:0] max_of(input logic [1:0] g);
        logic [SPEED_W-1:0] s;
        unique case (g)
            GEAR_1TO5:  s = 18'd200000;
            GEAR_16TO1: s = 18'd2500;
            default:    s = 18'd40000;
        endcase
        return s;
    endfunction

    function automatic logic [SPEED_W-1:0] min_of(input logic [1:0] g);
        logic [SPEED_W-1:0] s;
        unique case (g)
            GEAR_1TO5:  s = 18'd10000;
            GEAR_16TO1: s = 18'd100;
            default:    s = 18'd2000;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] led_of(input logic [1:0] g);
        logic [2:0] l;
        unique case (g)
            GEAR_1TO5:  l = 3'b100;
            GEAR_16TO1: l = 3'b001;
            default:    l = 3'b010;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        c = crc_in ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // reciprocal multiplies, each exact over its full input range (18-bit; 12-bit for div10)
    function automatic logic [15:0] div5(input logic [17:0] x);
        logic [36:0] p;
        p = {19'd0, x} * 37'd419431;
        return p[36:21];
    endfunction

    function automatic logic [11:0] div100(input logic [17:0] x);
        logic [37:0] p;
        p = {20'd0, x} * 38'd671089;
        return p[37:26];
    endfunction

    function automatic logic [8:0] div1000(input logic [17:0] x);
        logic [36:0] p;
        p = {19'd0, x} * 37'd268436;
        return p[36:28];
    endfunction

    function automatic logic [4:0] div10000(input logic [17:0] x);
        logic [36:0] p;
        p = {19'd0, x} * 37'd429497;
        return p[36:32];
    endfunction

    function automatic logic [8:0] div10(input logic [11:0] x);
        logic [23:0] p;
        p = {12'd0, x} * 24'd3277;
        return p[23:15];
    endfunction

endpackage

`default_nettype wire

/* rtl/gmsp_ctrl.sv */
// ----------------------------------------------------------------------------
// gmsp_ctrl
// Key tick register and panel state; applies one key action per cycle while i_en.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire gmsp_pkg::t_in_beat i_data,
    output logic                   o_stall,
    output logic                   o_snap_valid,
    output gmsp_pkg::t_snap        o_snap
);

    logic r_pm, r_pr, r_pu;
    logic r_long, r_up;
    logic n_pm, n_pr, n_pu;
    logic n_long, n_up;

    logic [1:0]                   r_gear, n_gear;
    logic [gmsp_pkg::SPEED_W-1:0] r_set, n_set;
    logic [gmsp_pkg::SPEED_W-1:0] r_saved [3];
    logic [gmsp_pkg::SPEED_W-1:0] n_saved [3];
    logic                         r_run, n_run;
    logic                         r_rev, n_rev;
    logic                         r_lock, n_lock;
    logic [4:0]                   r_led, n_led;

    logic                         r_snap_valid, n_snap_valid;
    gmsp_pkg::t_snap              r_snap, n_snap;

    logic                         act_m, act_r, act_u;
    logic                         rem_r, rem_u;
    logic                         take;
    logic [1:0]                   ng;
    logic [gmsp_pkg::SPEED_W-1:0] step;
    logic [gmsp_pkg::SPEED_W:0]   sum;

    always_comb begin
        act_m = r_pm;
        act_r = !r_pm && r_pr;
        act_u = !r_pm && !r_pr && r_pu;
        rem_r = act_m && r_pr;
        rem_u = (act_m || act_r) && r_pu;
        take  = i_en && !rem_r && !rem_u;
        o_stall = !take;

        if (take && i_valid) begin
            n_pm   = i_data.mode_key;
            n_pr   = i_data.run_key_long || i_data.run_key_release;
            n_pu   = i_data.up_key || i_data.down_key;
            n_long = i_data.run_key_long;
            n_up   = i_data.up_key;
        end else begin
            n_pm   = 1'b0;
            n_pr   = rem_r;
            n_pu   = rem_u;
            n_long = r_long;
            n_up   = r_up;
        end

        n_gear  = r_gear;
        n_set   = r_set;
        n_saved = r_saved;
        n_run   = r_run;
        n_rev   = r_rev;
        n_lock  = r_lock;
        n_led   = r_led;
        ng      = (r_gear >= gmsp_pkg::GEAR_16TO1) ? gmsp_pkg::GEAR_1TO1 : r_gear + 2'd1;
        step    = gmsp_pkg::step_of(r_gear);
        sum     = {1'b0, r_set} + {1'b0, step};

        if (act_m) begin
            if (r_gear != gmsp_pkg::GEAR_UNUSED) begin
                n_saved[r_gear] = r_set;
            end
            n_gear = ng;
            n_set  = r_saved[ng];
            n_led  = {r_led[4:3], gmsp_pkg::led_of(ng)};
        end else if (act_r) begin
            if (r_long) begin
                n_lock = 1'b1;
                n_run  = !r_run;
            end else if (r_lock) begin
                n_lock = 1'b0;
            end else if (!r_run) begin
                n_rev = !r_rev;
                n_led = {r_rev, !r_rev, r_led[2:0]};
            end
        end else if (act_u) begin
            if (r_up) begin
                if (sum > {1'b0, gmsp_pkg::max_of(r_gear)}) begin
                    n_set = gmsp_pkg::max_of(r_gear);
                end else begin
                    n_set = sum[gmsp_pkg::SPEED_W-1:0];
                end
            end else begin
                if (r_set < step + gmsp_pkg::min_of(r_gear)) begin
                    n_set = gmsp_pkg::min_of(r_gear);
                end else begin
                    n_set = r_set - step;
                end
            end
        end

        n_snap_valid     = act_m || act_r || act_u;
        n_snap.gear      = n_gear;
        n_snap.set_speed = n_set;
        n_snap.running   = n_run;
        n_snap.reverse   = n_rev;
        n_snap.led       = n_led;
        n_snap.last      = !rem_r && !rem_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm         <= 1'b0;
            r_pr         <= 1'b0;
            r_pu         <= 1'b0;
            r_long       <= 1'b0;
            r_up         <= 1'b0;
            r_gear       <= gmsp_pkg::GEAR_1TO1;
            r_set        <= gmsp_pkg::SAVED_RST_1TO1;
            r_saved[0]   <= gmsp_pkg::SAVED_RST_1TO1;
            r_saved[1]   <= gmsp_pkg::SAVED_RST_1TO5;
            r_saved[2]   <= gmsp_pkg::SAVED_RST_16TO1;
            r_run        <= 1'b0;
            r_rev        <= 1'b0;
            r_lock       <= 1'b0;
            r_led        <= gmsp_pkg::LED_RST;
            r_snap_valid <= 1'b0;
        end else if (i_en) begin
            r_pm         <= n_pm;
            r_pr         <= n_pr;
            r_pu         <= n_pu;
            r_long       <= n_long;
            r_up         <= n_up;
            r_gear       <= n_gear;
            r_set        <= n_set;
            r_saved      <= n_saved;
            r_run        <= n_run;
            r_rev        <= n_rev;
            r_lock       <= n_lock;
            r_led        <= n_led;
            r_snap_valid <= n_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

/* rtl/gmsp_fmt.sv */
// ----------------------------------------------------------------------------
// gmsp_fmt
// Frame formatter: gear ratio, display digits, frame bytes and CRC-8.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsp_fmt (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_snap_valid,
    input  wire gmsp_pkg::t_snap  i_snap,
    input  wire logic             i_stall,
    output logic                  o_en,
    output logic                  o_valid,
    output gmsp_pkg::t_out_beat   o_data
);

    typedef struct packed {
        logic [15:0] ms;
        logic [11:0] q;
        logic [1:0]  gear;
        logic        run;
        logic        rev;
        logic [4:0]  led;
        logic        last;
    } t_stg_b;

    typedef struct packed {
        logic [15:0] ms;
        logic [8:0]  thou;
        logic [11:0] hdr;
        logic [3:0]  dlo;
        logic [2:0]  dhi;
        logic [1:0]  gear;
        logic        run;
        logic        rev;
        logic [4:0]  led;
        logic        last;
    } t_stg_c;

    typedef struct packed {
        logic [15:0] ms;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  crc;
        logic [3:0]  dlo;
        logic [2:0]  dhi;
        logic [1:0]  gear;
        logic [4:0]  led;
        logic        last;
    } t_stg_d;

    logic                r_vb, r_vc, r_vd, r_ve, r_vo;
    t_stg_b              r_b, n_b;
    t_stg_c              r_c, n_c;
    t_stg_d              r_d, n_d;
    t_stg_d              r_e, n_e;
    gmsp_pkg::t_out_beat r_o, n_o;
    logic                en;
    logic [8:0]          qq;
    logic [11:0]         rem;
    logic [11:0]         hund;

    assign en = !(r_vo && i_stall);

    always_comb begin
        unique case (i_snap.gear)
            gmsp_pkg::GEAR_16TO1: begin
                n_b.ms = {i_snap.set_speed[11:0], 4'b0000};
                n_b.q  = gmsp_pkg::div100(i_snap.set_speed);
            end
            gmsp_pkg::GEAR_1TO5: begin
                n_b.ms = gmsp_pkg::div5(i_snap.set_speed);
                n_b.q  = {7'd0, gmsp_pkg::div10000(i_snap.set_speed)};
            end
            default: begin
                n_b.ms = i_snap.set_speed[15:0];
                n_b.q  = {3'd0, gmsp_pkg::div1000(i_snap.set_speed)};
            end
        endcase
        n_b.gear = i_snap.gear;
        n_b.run  = i_snap.running;
        n_b.rev  = i_snap.reverse;
        n_b.led  = i_snap.led;
        n_b.last = i_snap.last;
    end

    always_comb begin
        qq       = gmsp_pkg::div10(r_b.q);
        rem      = r_b.q - {qq, 3'b000} - {2'b00, qq, 1'b0};
        n_c.ms   = r_b.ms;
        n_c.thou = gmsp_pkg::div1000({2'b00, r_b.ms});
        n_c.hdr  = gmsp_pkg::div100({2'b00, r_b.ms});
        n_c.dlo  = rem[3:0];
        n_c.dhi  = qq[2:0];
        n_c.gear = r_b.gear;
        n_c.run  = r_b.run;
        n_c.rev  = r_b.rev;
        n_c.led  = r_b.led;
        n_c.last = r_b.last;
    end

    always_comb begin
        hund     = r_c.hdr - {r_c.thou, 3'b000} - {2'b00, r_c.thou, 1'b0};
        n_d.ms   = r_c.ms;
        n_d.b0   = r_c.thou[7:0];
        n_d.b1   = {hund[3:0], 2'b00, r_c.run, r_c.rev};
        n_d.crc  = gmsp_pkg::crc8_byte(8'h00, r_c.thou[7:0]);
        n_d.dlo  = r_c.dlo;
        n_d.dhi  = r_c.dhi;
        n_d.gear = r_c.gear;
        n_d.led  = r_c.led;
        n_d.last = r_c.last;
    end

    always_comb begin
        n_e     = r_d;
        n_e.crc = gmsp_pkg::crc8_byte(r_d.crc, r_d.b1);
    end

    always_comb begin
        n_o.thousands_byte = r_e.b0[5:0];
        n_o.flags_byte     = r_e.b1;
        n_o.spare_byte     = 1'b0;
        n_o.check_byte     = gmsp_pkg::crc8_byte(r_e.crc, 8'h00);
        n_o.motor_speed    = r_e.ms;
        n_o.led_pattern    = r_e.led;
        n_o.digit_low      = r_e.dlo;
        n_o.digit_high     = r_e.dhi;
        n_o.gear_now       = r_e.gear;
        n_o.last_frame     = r_e.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_vb <= i_snap_valid;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vo <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
            r_o <= n_o;
        end
    end

    assign o_en    = en;
    assign o_valid = r_vo;
    assign o_data  = r_o;

endmodule

`default_nettype wire

/* rtl/geared_motor_speed_panel_unit.sv */
// ----------------------------------------------------------------------------
// geared_motor_speed_panel_unit
// Speed panel for a geared motor, one key-scan tick per input beat.
// Input channel: one beat per tick with five key flags (i_valid, o_stall).
// Output channel: one beat per frame (o_valid, i_stall); a tick gives zero to
// three frames, the final one marked by last_frame.
// The action unit applies one key action per cycle while not stalled; the
// next tick is taken in the cycle that handles the last action of the
// current one. A tick without keys gives no action and does not hold it up.
// Each frame passes the key tick, snapshot and formatter b, c, d, e, o
// registers in turn; a tick's frames follow one per cycle while not stalled.
// Reset: gear 1:1, set speed 2000, stopped, forward, LEDs 0x12, no frames.
// A stall while a frame waits at the output freezes the whole pipeline and
// the action unit, so o_stall rises in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module geared_motor_speed_panel_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire gmsp_pkg::t_in_beat  i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output gmsp_pkg::t_out_beat      o_data
);

    logic            en;
    logic            snap_valid;
    gmsp_pkg::t_snap snap;

    gmsp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .o_stall      (o_stall),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    gmsp_fmt u_fmt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .i_stall      (i_stall),
        .o_en         (en),
        .o_valid      (o_valid),
        .o_data       (o_data)
    );

endmodule

`default_nettype wire

/* rtl/gmsp_chk.sv */
// ----------------------------------------------------------------------------
// gmsp_chk
// Port-level checker for the speed panel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gmsp_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire gmsp_pkg::t_in_beat  i_data,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire gmsp_pkg::t_out_beat o_data
);

    logic dir_led_ok;
    logic gear_led_ok;
    logic frame_fix_ok;

    assign dir_led_ok   = $onehot(o_data.led_pattern[4:3]) &&
                          (o_data.led_pattern[3] == o_data.flags_byte[0]);
    assign gear_led_ok  = $onehot(o_data.led_pattern[2:0]) &&
                          ((o_data.gear_now == gmsp_pkg::GEAR_1TO1) == o_data.led_pattern[1]);
    assign frame_fix_ok = (o_data.spare_byte == 1'b0) && (o_data.flags_byte[3:2] == 2'b00) &&
                          (o_data.motor_speed <= 16'd40000) && (o_data.digit_high <= 3'd4);

    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_data))

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

    `ASSERT_IMPLIES(a_dir_led, i_clk, i_rst_n, o_valid, dir_led_ok)

    `ASSERT_IMPLIES(a_gear_led, i_clk, i_rst_n, o_valid, gear_led_ok)

    `ASSERT_IMPLIES(a_frame_fix, i_clk, i_rst_n, o_valid, frame_fix_ok)

endmodule

bind geared_motor_speed_panel_unit gmsp_chk u_gmsp_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
